@@ rtl/core/lre_pkg.sv @@
package lre_pkg;

    // ascii codes the parser looks for
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    typedef logic [1:0] t_op;
    localparam t_op OP_PLUS  = 2'd0;
    localparam t_op OP_MINUS = 2'd1;
    localparam t_op OP_MUL   = 2'd2;
    localparam t_op OP_DIV   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_NO_FIRST   = 2'd1;
    localparam t_status ST_NO_OPERAND = 2'd2;
    localparam t_status ST_DIV_ZERO   = 2'd3;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic div_zero;
    } t_alu_rsp;

endpackage

@@ rtl/core/lre_if.sv @@
interface lre_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface lre_res_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] value;
    logic [1:0]        status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

@@ rtl/core/left_to_right_arith_evaluator.sv @@
// per character beat: a digit that does not end the operand is taken straight in S_IDLE;
// an operand ending under + or - goes through S_LAUNCH and S_WAIT to the alu, under * to the
// bit-serial shift-add alu, under / to its restoring divide (cut short on a zero divisor);
// the last character then passes S_EMIT to load the result register; one character at a time
// reset (synchronous, active low) clears the evaluator to expect a first number
module left_to_right_arith_evaluator #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lre_char_if.sink   i_char,
    lre_res_if.source  o_res
);
    import lre_pkg::*;

    localparam int W = VALUE_WIDTH;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LAUNCH = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_NUM   = 2'd1;
    localparam logic [1:0] PH_AFTER = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_phase, n_phase;
    logic [1:0]         r_after, n_after;
    logic [W-1:0]       r_acc, n_acc;
    logic [W-1:0]       r_opnd, n_opnd;
    t_op                r_pend, n_pend;
    t_op                r_nop, n_nop;
    t_status            r_err, n_err;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_value, n_value;
    t_status            r_status, n_status;

    logic               beat;
    logic               is_digit;
    logic [3:0]         digit_val;
    logic               is_op;
    t_op                op_code;
    logic               need_apply;
    logic [W-1:0]       opnd_x10;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    logic [W-1:0]       alu_result;

    assign i_char.ready = (r_state == S_IDLE);
    assign beat         = i_char.valid && i_char.ready;

    assign is_digit  = (i_char.char_code >= CH_ZERO) && (i_char.char_code <= CH_NINE);
    assign digit_val = 4'(i_char.char_code - CH_ZERO);
    // times ten as two shifted copies
    assign opnd_x10  = {r_opnd[W-4:0], 3'b000} + {r_opnd[W-2:0], 1'b0};

    always_comb begin
        is_op   = 1'b1;
        op_code = OP_PLUS;
        unique case (i_char.char_code)
            CH_PLUS:  op_code = OP_PLUS;
            CH_MINUS: op_code = OP_MINUS;
            CH_STAR:  op_code = OP_MUL;
            CH_SLASH: op_code = OP_DIV;
            default:  is_op = 1'b0;
        endcase
    end

    assign alu_req.start = (r_state == S_LAUNCH);
    assign alu_req.op    = r_pend;

    lre_alu #(
        .W (W)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_acc),
        .i_b      (r_opnd),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_after     = r_after;
        n_acc       = r_acc;
        n_opnd      = r_opnd;
        n_pend      = r_pend;
        n_nop       = r_nop;
        n_err       = r_err;
        n_last      = r_last;
        n_value     = r_value;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        need_apply  = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (beat) begin
                    unique case (r_phase)
                        PH_START, PH_AFTER: begin
                            if (is_digit) begin
                                n_opnd  = W'(digit_val);
                                n_phase = PH_NUM;
                            end else begin
                                n_err   = (r_phase == PH_START) ? ST_NO_FIRST : ST_NO_OPERAND;
                                n_phase = PH_DONE;
                            end
                        end
                        PH_NUM: begin
                            if (is_digit) begin
                                n_opnd = opnd_x10 + W'(digit_val);
                            end else begin
                                // operand ends: apply pending op, then take the new one
                                need_apply = 1'b1;
                                n_after    = is_op ? PH_AFTER : PH_DONE;
                                n_nop      = op_code;
                            end
                        end
                        default: ;
                    endcase
                    if (i_char.last_char && (n_phase == PH_NUM) && !need_apply) begin
                        need_apply = 1'b1;
                        n_after    = PH_DONE;
                    end
                    n_last = i_char.last_char;
                    if (need_apply) begin
                        n_state = S_LAUNCH;
                    end else if (i_char.last_char) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_LAUNCH: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    if (alu_rsp.div_zero) begin
                        n_err   = ST_DIV_ZERO;
                        n_phase = PH_DONE;
                    end else begin
                        n_acc   = alu_result;
                        n_opnd  = '0;
                        n_phase = r_after;
                        if (r_after == PH_AFTER) begin
                            n_pend = r_nop;
                        end
                    end
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    if (r_phase == PH_AFTER) begin
                        n_status = ST_NO_OPERAND;
                        n_value  = '0;
                    end else begin
                        n_status = r_err;
                        n_value  = (r_err == ST_OK) ? 32'($signed(r_acc)) : '0;
                    end
                    // back to the start of a new expression
                    n_acc   = '0;
                    n_opnd  = '0;
                    n_pend  = OP_PLUS;
                    n_phase = PH_START;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_START;
            r_acc       <= '0;
            r_opnd      <= '0;
            r_pend      <= OP_PLUS;
            r_err       <= ST_OK;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_opnd      <= n_opnd;
            r_pend      <= n_pend;
            r_err       <= n_err;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_after  <= n_after;
        r_nop    <= n_nop;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_value;
    assign o_res.status = r_status;

endmodule

@@ rtl/core/lre_alu.sv @@
module lre_alu #(
    parameter int W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lre_pkg::t_alu_req  i_req,
    input  logic [W-1:0]       i_a,
    input  logic [W-1:0]       i_b,
    output lre_pkg::t_alu_rsp  o_rsp,
    output logic [W-1:0]       o_result
);
    import lre_pkg::*;

    localparam int CW = $clog2(W + 1);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_FIX  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [W-1:0]  r_res, n_res;
    logic [W-1:0]  r_x, n_x;
    logic [W-1:0]  r_y, n_y;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_neg, n_neg;
    logic          r_done, n_done;
    logic          r_dz, n_dz;
    logic [W:0]    trial;

    // restoring divide: remainder in r_res, dividend shifts out of r_x as quotient shifts in
    assign trial = {r_res, r_x[W-1]} - {1'b0, r_y};

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_dz    = 1'b0;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    unique case (i_req.op)
                        OP_PLUS: begin
                            n_res  = i_a + i_b;
                            n_done = 1'b1;
                        end
                        OP_MINUS: begin
                            n_res  = i_a - i_b;
                            n_done = 1'b1;
                        end
                        OP_MUL: begin
                            n_res   = '0;
                            n_x     = i_a;
                            n_y     = i_b;
                            n_cnt   = CW'(W);
                            n_state = A_MUL;
                        end
                        OP_DIV: begin
                            if (i_b == '0) begin
                                n_done = 1'b1;
                                n_dz   = 1'b1;
                            end else begin
                                n_x     = i_a[W-1] ? -i_a : i_a;
                                n_y     = i_b[W-1] ? -i_b : i_b;
                                n_neg   = i_a[W-1] ^ i_b[W-1];
                                n_res   = '0;
                                n_cnt   = CW'(W);
                                n_state = A_DIV;
                            end
                        end
                    endcase
                end
            end
            A_MUL: begin
                if (r_y[0]) begin
                    n_res = r_res + r_x;
                end
                n_x   = {r_x[W-2:0], 1'b0};
                n_y   = {1'b0, r_y[W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = A_IDLE;
                    n_done  = 1'b1;
                end
            end
            A_DIV: begin
                if (!trial[W]) begin
                    n_res = trial[W-1:0];
                    n_x   = {r_x[W-2:0], 1'b1};
                end else begin
                    n_res = {r_res[W-2:0], r_x[W-1]};
                    n_x   = {r_x[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = A_FIX;
                end
            end
            A_FIX: begin
                n_res   = r_neg ? -r_x : r_x;
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_dz    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_dz    <= n_dz;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_x   <= n_x;
        r_y   <= n_y;
        r_neg <= n_neg;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_dz;
    assign o_result       = r_res;

endmodule
